// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define BPS_ASSERT(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// condition in one cycle implies consequence in the next
`define BPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/bps_pkg.sv =====
`default_nettype none

package bps_pkg;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_TRIGGER = 2'd1;
	localparam logic [1:0] CMD_STOP    = 2'd2;

	localparam logic [2:0] PAT_NONE      = 3'd0;
	localparam logic [2:0] PAT_STARTUP   = 3'd1;
	localparam logic [2:0] PAT_CONNECTED = 3'd2;
	localparam logic [2:0] PAT_LOCK      = 3'd3;
	localparam logic [2:0] PAT_WARNING   = 3'd4;
	localparam logic [2:0] NUM_PATTERNS  = 3'd5;

	localparam logic [10:0] LEN_SHORT   = 11'd100;
	localparam logic [10:0] LEN_LONG    = 11'd500;
	localparam logic [10:0] LEN_RAPID   = 11'd80;
	localparam logic [10:0] LEN_PAUSE   = 11'd2000;
	localparam logic [10:0] ELAPSED_MAX = 11'd2047;

	typedef struct packed {
		logic [2:0]  pattern;
		logic [2:0]  step_index;
		logic [10:0] elapsed;
		logic        repeat_mode;
		logic        sounding;
	} state_t;

	function automatic logic [2:0] pat_steps(input logic [2:0] p);
		logic [2:0] n;
		case (p)
			PAT_STARTUP:   n = 3'd1;
			PAT_CONNECTED: n = 3'd3;
			PAT_LOCK:      n = 3'd1;
			PAT_WARNING:   n = 3'd6;
			default:       n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [10:0] step_len(input logic [2:0] p, input logic [2:0] idx);
		logic [10:0] len;
		len = 11'd0;
		case (p)
			PAT_STARTUP: begin
				if (idx == 3'd0) len = LEN_SHORT;
			end
			PAT_CONNECTED: begin
				if (idx < 3'd3) len = LEN_SHORT;
			end
			PAT_LOCK: begin
				if (idx == 3'd0) len = LEN_LONG;
			end
			PAT_WARNING: begin
				if (idx < 3'd5) len = LEN_RAPID;
				else if (idx == 3'd5) len = LEN_PAUSE;
			end
			default: len = 11'd0;
		endcase
		return len;
	endfunction

	function automatic logic step_on(input logic [2:0] p, input logic [2:0] idx);
		logic on;
		on = 1'b0;
		case (p)
			PAT_STARTUP:   on = (idx == 3'd0);
			PAT_CONNECTED: on = (idx == 3'd0) || (idx == 3'd2);
			PAT_LOCK:      on = (idx == 3'd0);
			PAT_WARNING:   on = (idx == 3'd0) || (idx == 3'd2) || (idx == 3'd4);
			default:       on = 1'b0;
		endcase
		return on;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/bps_cmd_if.sv =====
`default_nettype none

interface bps_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [2:0] pattern;

	modport source (output valid, output command, output pattern, input ready);
	modport sink (input valid, input command, input pattern, output ready);
endinterface

`default_nettype wire

// ===== hdl/bps_res_if.sv =====
`default_nettype none

interface bps_res_if;
	logic       valid;
	logic       ready;
	logic       sound_on;
	logic       pin_level;
	logic       playing;
	logic [2:0] active_pattern;

	modport source (output valid, output sound_on, output pin_level, output playing,
		output active_pattern, input ready);
	modport sink (input valid, input sound_on, input pin_level, input playing,
		input active_pattern, output ready);
endinterface

`default_nettype wire

// ===== hdl/bps_step.sv =====
`default_nettype none

module bps_step (
	input  bps_pkg::state_t cur,
	input  logic [1:0]      command,
	input  logic [2:0]      pattern,
	output bps_pkg::state_t nxt
);

	logic [10:0]     len;
	logic [10:0]     elapsed_inc;
	logic [2:0]      idx_inc;
	logic [2:0]      steps;
	bps_pkg::state_t restart;
	bps_pkg::state_t trig;
	bps_pkg::state_t idle;

	always_comb begin
		len         = bps_pkg::step_len(cur.pattern, cur.step_index);
		steps       = bps_pkg::pat_steps(cur.pattern);
		elapsed_inc = (cur.elapsed != bps_pkg::ELAPSED_MAX) ? cur.elapsed + 11'd1 : cur.elapsed;
		idx_inc     = cur.step_index + 3'd1;

		idle = '0;

		restart.pattern     = cur.pattern;
		restart.step_index  = 3'd0;
		restart.elapsed     = 11'd0;
		restart.repeat_mode = (cur.pattern == bps_pkg::PAT_WARNING);
		restart.sounding    = bps_pkg::step_on(cur.pattern, 3'd0);

		trig.pattern     = pattern;
		trig.step_index  = 3'd0;
		trig.elapsed     = 11'd0;
		trig.repeat_mode = (pattern == bps_pkg::PAT_WARNING);
		trig.sounding    = bps_pkg::step_on(pattern, 3'd0);

		nxt = cur;
		case (command)
			bps_pkg::CMD_TICK: begin
				if (cur.pattern != bps_pkg::PAT_NONE) begin
					if (cur.pattern >= bps_pkg::NUM_PATTERNS) begin
						nxt = idle;
					end else if (cur.step_index >= steps) begin
						nxt = cur.repeat_mode ? restart : idle;
					end else if (elapsed_inc >= len) begin
						if (idx_inc >= steps) begin
							nxt = cur.repeat_mode ? restart : idle;
						end else begin
							nxt.step_index = idx_inc;
							nxt.elapsed    = 11'd0;
							nxt.sounding   = bps_pkg::step_on(cur.pattern, idx_inc);
						end
					end else begin
						nxt.elapsed = elapsed_inc;
					end
				end
			end
			bps_pkg::CMD_TRIGGER: begin
				if (pattern == bps_pkg::PAT_NONE || pattern >= bps_pkg::NUM_PATTERNS) begin
					nxt = idle;
				end else begin
					nxt = trig;
				end
			end
			bps_pkg::CMD_STOP: begin
				nxt = idle;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/beep_pattern_sequencer.sv =====
// channel   dir   payload                                       transfer
// cmd       in    command[1:0], pattern[2:0]                    valid & ready
// res       out   sound_on, pin_level, playing, active_pattern  valid & ready
//
// one command taken every cycle unless a held result stalls the command register;
// its result is offered after the command register, step logic and result register
// the step logic is table lookups, an 11-bit and a 3-bit increment and compares
// reset clears both valid flags and puts the sequencer idle; result data is not reset
// a held result stalls the command register; ready drops only when both are full

`default_nettype none
`include "assert_macros.svh"

module beep_pattern_sequencer (
	input logic       clk,
	input logic       arst_n,
	bps_cmd_if.sink   cmd,
	bps_res_if.source res
);

	logic            valid_s1;
	logic [1:0]      command_s1;
	logic [2:0]      pattern_s1;
	logic            valid_s2;
	logic            sound_on_s2;
	logic            playing_s2;
	logic [2:0]      active_pattern_s2;
	bps_pkg::state_t state_q;
	bps_pkg::state_t state_nxt;
	logic            advance;

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	bps_step u_step (
		.cur     (state_q),
		.command (command_s1),
		.pattern (pattern_s1),
		.nxt     (state_nxt)
	);

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1 <= cmd.command;
			pattern_s1 <= cmd.pattern;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sound_on_s2       <= state_nxt.sounding;
			playing_s2        <= (state_nxt.pattern != bps_pkg::PAT_NONE);
			active_pattern_s2 <= state_nxt.pattern;
		end
	end

	assign res.valid          = valid_s2;
	assign res.sound_on       = sound_on_s2;
	assign res.pin_level      = !sound_on_s2;
	assign res.playing        = playing_s2;
	assign res.active_pattern = active_pattern_s2;

	`BPS_ASSERT_NEXT(a_advance_fills_result, clk, arst_n, advance, valid_s2)
	`BPS_ASSERT(a_not_ready_only_when_held, clk, arst_n, cmd.ready || valid_s1)
	`BPS_ASSERT(a_idle_is_clean, clk, arst_n, (state_q.pattern != bps_pkg::PAT_NONE) || (!state_q.sounding && state_q.step_index == 3'd0 && state_q.elapsed == 11'd0 && !state_q.repeat_mode))
	`BPS_ASSERT(a_elapsed_below_len, clk, arst_n, (state_q.pattern == bps_pkg::PAT_NONE) || (state_q.elapsed < bps_pkg::step_len(state_q.pattern, state_q.step_index)))

endmodule

`default_nettype wire
